### rtl/core/pmba_pkg.sv
// Package with shared types and constants of the pixel mosaic block average unit.
`default_nettype none
package pmba_pkg;

	localparam int DEF_MAX_WIDTH = 2048;
	localparam int DEF_MAX_CELL  = 64;
	localparam int SUM_W         = 20;
	localparam int ROW_MAX       = 4095;

	localparam logic [1:0] REG_CELL_WIDTH  = 2'd0;
	localparam logic [1:0] REG_CELL_HEIGHT = 2'd1;
	localparam logic [1:0] REG_IMAGE_WIDTH = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIVIDE,
		ST_OUTPUT
	} pmba_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take_pixel;
		logic start_read;
		logic finish_cell;
		logic div_start;
		logic out_load;
	} pmba_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic emit;
		logic div_busy;
	} pmba_stat_t;

endpackage
`default_nettype wire

### rtl/core/pmba_ctrl.sv
// Controller state machine of the pixel mosaic block average unit.
`default_nettype none
module pmba_ctrl
	import pmba_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire        out_free,
	input  pmba_stat_t stat,
	output pmba_cmd_t  cmd
);

	pmba_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (stat.emit) begin
					state_d = ST_DIVIDE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIVIDE: begin
				if (!stat.div_busy) begin
					state_d = ST_OUTPUT;
				end
			end
			ST_OUTPUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take_pixel = in_valid;
			end
			ST_READ: begin
				cmd.finish_cell = 1'b1;
				cmd.div_start = stat.emit;
			end
			ST_DIVIDE: begin
			end
			ST_OUTPUT: begin
				cmd.out_load = out_free;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

### rtl/core/pmba_divider.sv
// Restoring divider that divides three channel sums by the cell area, one bit a cycle.
`default_nettype none
module pmba_divider
	import pmba_pkg::*;
#(
	parameter int AREA_W = 13
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire  [3*SUM_W-1:0]  sums,
	input  wire  [AREA_W-1:0]   area,
	output logic                busy,
	output logic [3*SUM_W-1:0]  quots
);

	localparam int CNT_W = $clog2(SUM_W + 1);

	logic [CNT_W-1:0]   count_q;
	logic [AREA_W-1:0]  area_q;
	logic [AREA_W:0]    rem_q [3];
	logic [SUM_W-1:0]   num_q [3];

	assign busy = (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (start) begin
			count_q <= CNT_W'(SUM_W);
		end else if (busy) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			area_q <= area;
			for (int k = 0; k < 3; k++) begin
				rem_q[k] <= '0;
				num_q[k] <= sums[k*SUM_W +: SUM_W];
			end
		end else if (busy) begin
			for (int k = 0; k < 3; k++) begin
				logic [AREA_W+1:0] trial;
				trial = {rem_q[k], num_q[k][SUM_W-1]};
				if (trial >= {1'b0, 1'b0, area_q}) begin
					rem_q[k] <= (AREA_W+1)'(trial - {2'b00, area_q});
					num_q[k] <= {num_q[k][SUM_W-2:0], 1'b1};
				end else begin
					rem_q[k] <= trial[AREA_W:0];
					num_q[k] <= {num_q[k][SUM_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quots = {num_q[2], num_q[1], num_q[0]};

endmodule
`default_nettype wire

### rtl/core/pmba_datapath.sv
// Datapath of the pixel mosaic block average unit: counters, column sum memory, output.
`default_nettype none
module pmba_datapath
	import pmba_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_CELL  = DEF_MAX_CELL
) (
	input  wire         clk,
	input  wire         arst_n,
	input  pmba_cmd_t   cmd,
	output pmba_stat_t  stat,
	input  wire  [6:0]  cell_width,
	input  wire  [6:0]  cell_height,
	input  wire  [11:0] image_width,
	input  wire  [7:0]  red,
	input  wire  [7:0]  green,
	input  wire  [7:0]  blue,
	input  wire         frame_start,
	input  wire         out_ready,
	output logic        out_valid,
	output logic [10:0] cell_col,
	output logic [11:0] cell_row,
	output logic [7:0]  red_mean,
	output logic [7:0]  green_mean,
	output logic [7:0]  blue_mean
);

	localparam int AW     = $clog2(MAX_WIDTH);
	localparam int CW     = $clog2(MAX_CELL + 1);
	localparam int IW     = $clog2(MAX_WIDTH + 1);
	localparam int AREA_W = 2 * CW;
	localparam int PACK_W = 3 * SUM_W;

	logic [PACK_W-1:0] col_mem [MAX_WIDTH];

	logic [AW-1:0]     pixel_col_q;
	logic [CW-1:0]     row_in_cell_q;
	logic [CW-1:0]     col_in_cell_q;
	logic [IW-1:0]     cell_col_idx_q;
	logic [11:0]       cell_row_idx_q;
	logic [PACK_W-1:0] running_q;

	// Clamped register values.
	logic [CW-1:0] cw, ch;
	logic [IW-1:0] iw;
	always_comb begin
		cw = (cell_width == 7'd0) ? CW'(1) :
			({25'd0, cell_width} > 32'(MAX_CELL)) ? CW'(MAX_CELL) : CW'(cell_width);
		ch = (cell_height == 7'd0) ? CW'(1) :
			({25'd0, cell_height} > 32'(MAX_CELL)) ? CW'(MAX_CELL) : CW'(cell_height);
		iw = (image_width == 12'd0) ? IW'(1) :
			({20'd0, image_width} > 32'(MAX_WIDTH)) ? IW'(MAX_WIDTH) : IW'(image_width);
	end

	// Pixel stage register (frame start applied).
	logic              inc_s1, cdone_s1, emit_s1, row0_s1;
	logic [AW-1:0]     addr_s1;
	logic [PACK_W-1:0] rsum_s1;
	logic [PACK_W-1:0] rd_s1;
	logic [10:0]       ocol_s1;
	logic [11:0]       orow_s1;

	logic [AW-1:0]     pc;
	logic [CW-1:0]     ric, cic;
	logic [IW-1:0]     cci;
	logic [11:0]       cri;
	logic [PACK_W-1:0] rs, rs_add, pix;
	logic              cdone, row_end, row_last;

	always_comb begin
		pc  = frame_start ? '0 : pixel_col_q;
		ric = frame_start ? '0 : row_in_cell_q;
		cic = frame_start ? '0 : col_in_cell_q;
		cci = frame_start ? '0 : cell_col_idx_q;
		cri = frame_start ? '0 : cell_row_idx_q;
		rs  = frame_start ? '0 : running_q;
		pix = {12'd0, blue, 12'd0, green, 12'd0, red};
		for (int k = 0; k < 3; k++) begin
			rs_add[k*SUM_W +: SUM_W] = rs[k*SUM_W +: SUM_W] + pix[k*SUM_W +: SUM_W];
		end
		cdone    = ({1'b0, cic} + 1'b1) >= {1'b0, cw};
		row_end  = ({1'b0, pc} + 1'b1) >= IW'(iw);
		row_last = ({1'b0, ric} + 1'b1) >= {1'b0, ch};
	end

	// A cell is in range when its right edge stays within the row; this uses the
	// column index after frame start has been applied.
	logic [IW+CW:0] cell_end_a;
	logic           act;
	assign cell_end_a = ({{(CW+1){1'b0}}, cci} + 1'b1) * {{(IW+1){1'b0}}, cw};
	assign act = cell_end_a <= {{(CW+1){1'b0}}, iw};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_col_q    <= '0;
			row_in_cell_q  <= '0;
			col_in_cell_q  <= '0;
			cell_col_idx_q <= '0;
			cell_row_idx_q <= '0;
			running_q      <= '0;
			inc_s1         <= 1'b0;
		end else begin
			inc_s1 <= cmd.take_pixel && act && cdone;
			if (cmd.take_pixel) begin
				if (row_end) begin
					pixel_col_q    <= '0;
					col_in_cell_q  <= '0;
					cell_col_idx_q <= '0;
					running_q      <= '0;
					if (row_last) begin
						row_in_cell_q  <= '0;
						cell_row_idx_q <= (cri < 12'(ROW_MAX)) ? cri + 1'b1 : cri;
					end else begin
						row_in_cell_q  <= ric + 1'b1;
						cell_row_idx_q <= cri;
					end
				end else begin
					pixel_col_q    <= pc + 1'b1;
					row_in_cell_q  <= ric;
					cell_row_idx_q <= cri;
					if (act && cdone) begin
						running_q      <= '0;
						col_in_cell_q  <= '0;
						cell_col_idx_q <= cci + 1'b1;
					end else if (act) begin
						running_q      <= rs_add;
						col_in_cell_q  <= cic + 1'b1;
						cell_col_idx_q <= cci;
					end else begin
						running_q      <= rs;
						col_in_cell_q  <= cic;
						cell_col_idx_q <= cci;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_pixel) begin
			cdone_s1 <= act && cdone;
			emit_s1  <= act && cdone && row_last;
			row0_s1  <= (ric == '0);
			addr_s1  <= AW'(cci);
			rsum_s1  <= rs_add;
			ocol_s1  <= 11'(cci);
			orow_s1  <= cri;
			rd_s1    <= col_mem[AW'(cci)];
		end
	end

	// Read-modify-write of the column sum.
	logic [PACK_W-1:0] new_col;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			new_col[k*SUM_W +: SUM_W] = (row0_s1 ? '0 : rd_s1[k*SUM_W +: SUM_W])
				+ rsum_s1[k*SUM_W +: SUM_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish_cell && cdone_s1) begin
			col_mem[addr_s1] <= new_col;
		end
	end

	assign stat.emit = emit_s1 && inc_s1;

	logic [AREA_W-1:0] area;
	assign area = AREA_W'({{CW{1'b0}}, cw} * {{CW{1'b0}}, ch});

	logic              div_busy;
	logic [PACK_W-1:0] quots;
	pmba_divider #(.AREA_W(AREA_W)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.sums  (new_col),
		.area  (area),
		.busy  (div_busy),
		.quots (quots)
	);
	assign stat.div_busy = div_busy;

	function automatic logic [7:0] sat8(input logic [SUM_W-1:0] v);
		return (v > SUM_W'(255)) ? 8'hFF : v[7:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cell_col   <= ocol_s1;
			cell_row   <= orow_s1;
			red_mean   <= sat8(quots[0 +: SUM_W]);
			green_mean <= sat8(quots[SUM_W +: SUM_W]);
			blue_mean  <= sat8(quots[2*SUM_W +: SUM_W]);
		end
	end

endmodule
`default_nettype wire

### rtl/core/pixel_mosaic_block_average_unit.sv
// Top level of the pixel mosaic block average unit.
`default_nettype none
// Pixel mosaic block average: RGB pixels arrive in raster order on the s_axis
// side, one request per pixel, and each channel is summed over cells of
// cell_width by cell_height pixels. When the bottom-right pixel of a cell
// that ends within the image width is taken, one request leaves on m_axis
// with the cell's column and row and the floor of each channel mean. A pixel
// that finishes no cell is accepted and then goes through the column sum
// memory read-modify-write. A pixel that finishes a cell then also goes
// through the bit-serial divider, which produces one quotient bit per cycle
// and then reports done, and the load of the output register, plus any wait
// for m_axis_tready while an earlier request still sits there.
// Configuration writes go through cfg_we, cfg_addr and cfg_data and must only
// happen while the block is idle.
module pixel_mosaic_block_average_unit
	import pmba_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_CELL  = DEF_MAX_CELL
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_addr,
	input  wire  [11:0] cfg_data,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// Fields from bit 0: red[7:0], green[15:8], blue[23:16].
	input  wire  [23:0] s_axis_tdata,
	// Fields from bit 0: frame_start[0].
	input  wire         s_axis_tuser,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// Fields from bit 0: cell_col[10:0], cell_row[22:11], red_mean[30:23],
	// green_mean[38:31], blue_mean[46:39], zero fill [47].
	output logic [47:0] m_axis_tdata
);

	logic [6:0]  cell_width_q, cell_height_q;
	logic [11:0] image_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q  <= 7'd8;
			cell_height_q <= 7'd8;
			image_width_q <= 12'd640;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_CELL_WIDTH:  cell_width_q  <= cfg_data[6:0];
				REG_CELL_HEIGHT: cell_height_q <= cfg_data[6:0];
				REG_IMAGE_WIDTH: image_width_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pmba_cmd_t  cmd;
	pmba_stat_t stat;
	logic       out_free;
	logic [10:0] cell_col;
	logic [11:0] cell_row;
	logic [7:0]  red_mean, green_mean, blue_mean;

	// The output register may be reloaded when empty or being taken.
	assign out_free = !m_axis_tvalid || m_axis_tready;

	pmba_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.out_free(out_free),
		.stat    (stat),
		.cmd     (cmd)
	);

	pmba_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_CELL(MAX_CELL)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cell_width (cell_width_q),
		.cell_height(cell_height_q),
		.image_width(image_width_q),
		.red        (s_axis_tdata[7:0]),
		.green      (s_axis_tdata[15:8]),
		.blue       (s_axis_tdata[23:16]),
		.frame_start(s_axis_tuser),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.cell_col   (cell_col),
		.cell_row   (cell_row),
		.red_mean   (red_mean),
		.green_mean (green_mean),
		.blue_mean  (blue_mean)
	);

	assign m_axis_tdata = {1'b0, blue_mean, green_mean, red_mean, cell_row, cell_col};

endmodule
`default_nettype wire
